[sv/speck_pkg.sv]
package speck_pkg;

  localparam int WORD_W = 16;
  localparam int KEY_W  = 64;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 4;
  localparam int ALPHA  = 7;
  localparam int BETA   = 2;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic REG_CIPHER_KEY = 1'b0;

  function automatic word_t rot_r(input word_t v, input int amt);
    rot_r = (v >> amt) | (v << (WORD_W - amt));
  endfunction

  function automatic word_t rot_l(input word_t v, input int amt);
    rot_l = (v << amt) | (v >> (WORD_W - amt));
  endfunction

endpackage

[sv/speck32_64_block_cipher_top.sv]
// Speck32/64 engine with one register stage per round. A block is accepted
// when start is high and busy is low, and its result appears on the out_
// ports for one cycle, marked by out_valid, after passing through every round
// stage; a new block may enter every cycle while busy is low, and the
// receiver cannot stall the output. A write of the 64-bit key at any byte
// address below 8 reloads the round key store, which the key schedule fills
// one round key per cycle, so busy stays high after each key write until the
// last round key is stored. Write the key only while no block is in flight.
module speck32_64_block_cipher_top #(
  parameter int ROUND_COUNT = 22
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [speck_pkg::WORD_W-1:0]  in_block_first_word,
  input  logic [speck_pkg::WORD_W-1:0]  in_block_second_word,
  output logic                          out_valid,
  output logic [speck_pkg::WORD_W-1:0]  out_result_first_word,
  output logic [speck_pkg::WORD_W-1:0]  out_result_second_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [speck_pkg::ADDR_W-1:0]  paddr,
  input  logic [speck_pkg::DATA_W-1:0]  pwdata,
  output logic [speck_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int IDX_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  logic [speck_pkg::KEY_W-1:0] key_r;
  speck_pkg::word_t            rk_r [ROUND_COUNT];
  speck_pkg::word_t            ks_k_r, ks_l0_r, ks_l1_r, ks_l2_r;
  speck_pkg::word_t            ks_nl, ks_k_nxt;
  logic [IDX_W-1:0]            ks_cnt_r;
  logic                        expand_r;
  logic                        key_wr, key_sel, accept;

  logic                        vld_r [ROUND_COUNT];
  logic                        op_r  [ROUND_COUNT];
  speck_pkg::word_t            y_r   [ROUND_COUNT];
  speck_pkg::word_t            x_r   [ROUND_COUNT];
  speck_pkg::word_t            y_nxt [ROUND_COUNT];
  speck_pkg::word_t            x_nxt [ROUND_COUNT];

  assign pready  = 1'b1;
  assign key_sel = (paddr[speck_pkg::ADDR_W-1] == speck_pkg::REG_CIPHER_KEY);
  assign key_wr  = psel && penable && pwrite && pready && key_sel;
  assign prdata  = key_sel ? key_r : '0;

  assign busy   = expand_r;
  assign accept = start && !busy;

  // key schedule: one round key per cycle
  assign ks_nl    = (ks_k_r + speck_pkg::rot_r(ks_l0_r, speck_pkg::ALPHA)) ^
                    speck_pkg::WORD_W'(ks_cnt_r);
  assign ks_k_nxt = speck_pkg::rot_l(ks_k_r, speck_pkg::BETA) ^ ks_nl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      expand_r <= 1'b0;
      ks_cnt_r <= '0;
    end else if (key_wr) begin
      key_r    <= pwdata;
      expand_r <= (ROUND_COUNT > 1);
      ks_cnt_r <= '0;
    end else if (expand_r) begin
      ks_cnt_r <= ks_cnt_r + 1'b1;
      if (ks_cnt_r == IDX_W'(ROUND_COUNT - 2)) begin
        expand_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr) begin
      rk_r[0] <= pwdata[speck_pkg::WORD_W-1:0];
      ks_k_r  <= pwdata[speck_pkg::WORD_W-1:0];
      ks_l0_r <= pwdata[2*speck_pkg::WORD_W-1:speck_pkg::WORD_W];
      ks_l1_r <= pwdata[3*speck_pkg::WORD_W-1:2*speck_pkg::WORD_W];
      ks_l2_r <= pwdata[4*speck_pkg::WORD_W-1:3*speck_pkg::WORD_W];
    end else if (expand_r) begin
      rk_r[ks_cnt_r + 1'b1] <= ks_k_nxt;
      ks_k_r  <= ks_k_nxt;
      ks_l0_r <= ks_l1_r;
      ks_l1_r <= ks_l2_r;
      ks_l2_r <= ks_nl;
    end
  end

  // round pipeline: stage s applies round s (encrypt) or the inverse of round ROUND_COUNT-1-s (decrypt)
  always_comb begin
    speck_pkg::word_t xi, yi, t;
    logic             oi;
    for (int s = 0; s < ROUND_COUNT; s++) begin
      if (s == 0) begin
        xi = in_block_second_word;
        yi = in_block_first_word;
        oi = in_opcode;
      end else begin
        xi = x_r[s-1];
        yi = y_r[s-1];
        oi = op_r[s-1];
      end
      if (oi == speck_pkg::OP_ENCRYPT) begin
        t        = (speck_pkg::rot_r(xi, speck_pkg::ALPHA) + yi) ^ rk_r[s];
        x_nxt[s] = t;
        y_nxt[s] = speck_pkg::rot_l(yi, speck_pkg::BETA) ^ t;
      end else begin
        t        = speck_pkg::rot_r(yi ^ xi, speck_pkg::BETA);
        y_nxt[s] = t;
        x_nxt[s] = speck_pkg::rot_l((xi ^ rk_r[ROUND_COUNT-1-s]) - t, speck_pkg::ALPHA);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ROUND_COUNT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int s = 1; s < ROUND_COUNT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r[0] <= in_opcode;
    for (int s = 1; s < ROUND_COUNT; s++) begin
      op_r[s] <= op_r[s-1];
    end
    for (int s = 0; s < ROUND_COUNT; s++) begin
      x_r[s] <= x_nxt[s];
      y_r[s] <= y_nxt[s];
    end
  end

  assign out_valid              = vld_r[ROUND_COUNT-1];
  assign out_result_first_word  = y_r[ROUND_COUNT-1];
  assign out_result_second_word = x_r[ROUND_COUNT-1];

endmodule

[sv/speck_chk.sv]
module speck_chk #(
  parameter int ROUND_COUNT = 22
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [speck_pkg::ADDR_W-1:0] paddr,
  input logic                         pready
);

  logic key_wr;

  assign key_wr = psel && penable && pwrite && pready &&
                  (paddr[speck_pkg::ADDR_W-1] == speck_pkg::REG_CIPHER_KEY);

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##ROUND_COUNT out_valid)
    else $error("accepted block produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, ROUND_COUNT))
    else $error("result without a matching transaction");

  a_key_expand_busy: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |=> (busy || (ROUND_COUNT < 2)))
    else $error("key write did not hold off new blocks");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("reset left work in flight");

endmodule

bind speck32_64_block_cipher_top speck_chk #(.ROUND_COUNT(ROUND_COUNT)) u_speck_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pready    (pready)
);

[tb/sv/testbench.sv]
module testbench;

  localparam int ROUND_COUNT = 22;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [speck_pkg::ADDR_W-1:0] ADDR_CIPHER_KEY =
    speck_pkg::ADDR_W'(8 * speck_pkg::REG_CIPHER_KEY);
  localparam logic [speck_pkg::ADDR_W-1:0] ADDR_UNMAPPED   = speck_pkg::ADDR_W'(8);
  localparam logic [speck_pkg::KEY_W-1:0]  KEY_PUBLISHED   = 64'h1918_1110_0908_0100;

  typedef struct {
    logic             op;
    speck_pkg::word_t y;
    speck_pkg::word_t x;
  } block_cmd_t;

  typedef struct {
    speck_pkg::word_t y;
    speck_pkg::word_t x;
  } block_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_opcode = speck_pkg::OP_ENCRYPT;
  speck_pkg::word_t              in_block_first_word = '0;
  speck_pkg::word_t              in_block_second_word = '0;
  logic                          out_valid;
  speck_pkg::word_t              out_result_first_word;
  speck_pkg::word_t              out_result_second_word;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [speck_pkg::ADDR_W-1:0]  paddr = '0;
  logic [speck_pkg::DATA_W-1:0]  pwdata = '0;
  logic [speck_pkg::DATA_W-1:0]  prdata;
  logic                          pready;

  block_cmd_t  block_queue[$];
  block_t      cipher_out_q[$];
  logic [speck_pkg::KEY_W-1:0] key_shadow = '0;
  speck_pkg::word_t            round_key_tbl [ROUND_COUNT];

  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int blocks_accepted = 0;
  int encrypt_count = 0;
  int decrypt_count = 0;
  int results_checked = 0;
  int key_writes = 0;

  speck32_64_block_cipher_top #(
    .ROUND_COUNT(ROUND_COUNT)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_opcode              (in_opcode),
    .in_block_first_word    (in_block_first_word),
    .in_block_second_word   (in_block_second_word),
    .out_valid              (out_valid),
    .out_result_first_word  (out_result_first_word),
    .out_result_second_word (out_result_second_word),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #5 clk = ~clk;

  function automatic speck_pkg::word_t rotr16(input speck_pkg::word_t v, input int n);
    return (v >> n) | (v << (speck_pkg::WORD_W - n));
  endfunction

  function automatic speck_pkg::word_t rotl16(input speck_pkg::word_t v, input int n);
    return (v << n) | (v >> (speck_pkg::WORD_W - n));
  endfunction

  function automatic void expand_schedule(input logic [speck_pkg::KEY_W-1:0] key);
    speck_pkg::word_t k;
    speck_pkg::word_t nl;
    speck_pkg::word_t l [3];
    k = key[15:0];
    l[0] = key[31:16];
    l[1] = key[47:32];
    l[2] = key[63:48];
    round_key_tbl[0] = k;
    for (int i = 0; i < ROUND_COUNT - 1; i++) begin
      nl = speck_pkg::word_t'(k + rotr16(l[0], speck_pkg::ALPHA)) ^ speck_pkg::word_t'(i);
      k = rotl16(k, speck_pkg::BETA) ^ nl;
      l[0] = l[1];
      l[1] = l[2];
      l[2] = nl;
      round_key_tbl[i+1] = k;
    end
  endfunction

  function automatic block_t speck_cipher(input logic op, input speck_pkg::word_t y,
                                          input speck_pkg::word_t x);
    block_t b;
    if (op == speck_pkg::OP_ENCRYPT) begin
      for (int r = 0; r < ROUND_COUNT; r++) begin
        x = speck_pkg::word_t'(rotr16(x, speck_pkg::ALPHA) + y) ^ round_key_tbl[r];
        y = rotl16(y, speck_pkg::BETA) ^ x;
      end
    end else begin
      for (int r = 0; r < ROUND_COUNT; r++) begin
        y = rotr16(y ^ x, speck_pkg::BETA);
        x = x ^ round_key_tbl[ROUND_COUNT-1-r];
        x = rotl16(speck_pkg::word_t'(x - y), speck_pkg::ALPHA);
      end
    end
    b.y = y;
    b.x = x;
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    logic taken;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        cipher_out_q.push_back(speck_cipher(block_queue[0].op, block_queue[0].y,
                                            block_queue[0].x));
        if (block_queue[0].op == speck_pkg::OP_ENCRYPT) encrypt_count++;
        else decrypt_count++;
        void'(block_queue.pop_front());
        blocks_accepted++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end
      if (start && !taken) begin
        // hold the transaction until busy drops
      end else if (gap_left > 0 || block_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
        in_opcode <= 1'($urandom);
        in_block_first_word <= speck_pkg::word_t'($urandom);
        in_block_second_word <= speck_pkg::word_t'($urandom);
      end else begin
        start <= 1'b1;
        in_opcode <= block_queue[0].op;
        in_block_first_word <= block_queue[0].y;
        in_block_second_word <= block_queue[0].x;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    block_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (cipher_out_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: y=%h x=%h",
                                  out_result_first_word, out_result_second_word));
      end else begin
        want = cipher_out_q.pop_front();
        results_checked++;
        if (out_result_first_word !== want.y)
          report_mismatch($sformatf("result_first_word got %h want %h",
                                    out_result_first_word, want.y));
        if (out_result_second_word !== want.x)
          report_mismatch($sformatf("result_second_word got %h want %h",
                                    out_result_second_word, want.x));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic apb_write(input logic [speck_pkg::ADDR_W-1:0] addr,
                           input logic [speck_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_CIPHER_KEY) begin
      key_shadow = data;
      expand_schedule(data);
    end
    key_writes++;
  endtask

  task automatic check_key_readback();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_CIPHER_KEY;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== key_shadow)
      report_mismatch($sformatf("cipher_key read %h want %h", prdata, key_shadow));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (block_queue.size() != 0 || start || cipher_out_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic queue_block(input logic op, input speck_pkg::word_t y,
                             input speck_pkg::word_t x);
    block_cmd_t c;
    c.op = op;
    c.y = y;
    c.x = x;
    block_queue.push_back(c);
  endtask

  // mostly random blocks, some corner words, some round trips of a prior result
  task automatic queue_random_blocks(input int n);
    block_t b;
    speck_pkg::word_t corner [4];
    corner[0] = 16'h0000;
    corner[1] = 16'hFFFF;
    corner[2] = 16'h8000;
    corner[3] = 16'h0001;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          queue_block(1'($urandom), corner[$urandom_range(0, 3)],
                      corner[$urandom_range(0, 3)]);
        end
        1, 2: begin
          b = speck_cipher(speck_pkg::OP_ENCRYPT, speck_pkg::word_t'($urandom),
                           speck_pkg::word_t'($urandom));
          queue_block(speck_pkg::OP_DECRYPT, b.y, b.x);
        end
        default: begin
          queue_block(1'($urandom), speck_pkg::word_t'($urandom),
                      speck_pkg::word_t'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    block_t b;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_write(ADDR_CIPHER_KEY, KEY_PUBLISHED);
    check_key_readback();
    queue_block(speck_pkg::OP_ENCRYPT, 16'h694C, 16'h6574);
    queue_block(speck_pkg::OP_DECRYPT, 16'h42F2, 16'hA868);
    for (int op = 0; op < 2; op++) begin
      queue_block(1'(op), 16'h0000, 16'h0000);
      queue_block(1'(op), 16'hFFFF, 16'hFFFF);
      queue_block(1'(op), 16'hFFFF, 16'h0000);
      queue_block(1'(op), 16'h0000, 16'hFFFF);
      queue_block(1'(op), 16'h8000, 16'h0001);
      queue_block(1'(op), 16'h0001, 16'h8000);
      queue_block(1'(op), 16'hAAAA, 16'h5555);
    end
    b = speck_cipher(speck_pkg::OP_ENCRYPT, 16'h1234, 16'hABCD);
    queue_block(speck_pkg::OP_DECRYPT, b.y, b.x);
    b = speck_cipher(speck_pkg::OP_DECRYPT, 16'hFEDC, 16'h0F0F);
    queue_block(speck_pkg::OP_ENCRYPT, b.y, b.x);
    wait_idle();

    apb_write(ADDR_CIPHER_KEY, 64'h0);
    check_key_readback();
    queue_random_blocks(150);
    wait_idle();

    apb_write(ADDR_CIPHER_KEY, {speck_pkg::KEY_W{1'b1}});
    check_key_readback();
    queue_random_blocks(150);
    wait_idle();

    // unmapped write must leave the key and round keys alone
    apb_write(ADDR_UNMAPPED, {$urandom, $urandom});
    check_key_readback();
    queue_random_blocks(100);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      apb_write(ADDR_CIPHER_KEY, {$urandom, $urandom});
      check_key_readback();
      queue_random_blocks(190);
      wait_idle();
    end

    repeat (ROUND_COUNT + 4) @(posedge clk);
    if (cipher_out_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", cipher_out_q.size()));

    $display("Covered %0d blocks (%0d encrypt, %0d decrypt), %0d results checked,",
             blocks_accepted, encrypt_count, decrypt_count, results_checked);
    $display("%0d register writes across 9 key settings, %0d mismatches",
             key_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
